// File: rtl/core/mtes_pkg.sv
// Shared types, constants and helpers for the MIDI track event serializer.
package mtes_pkg;

  // Tick handling: the low TICK_BITS bits of the tick field form a signed value
  localparam int TICK_W    = 32;
  localparam int TICK_BITS = 32;
  localparam int LT_W      = TICK_BITS - 1;
  // Seven-bit groups of the variable-length delta
  localparam int NGRP      = (LT_W + 6) / 7;
  localparam int DLY_W     = NGRP * 7;
  localparam int GRP_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
  // Byte position within one event (delta bytes plus three event bytes)
  localparam int POS_W     = $clog2(NGRP + 3);
  // Job queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_NOTE_ON  = 2'd0,
    REQ_NOTE_OFF = 2'd1,
    REQ_CTRL     = 2'd2,
    REQ_EOT      = 2'd3
  } req_t;

  localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
  localparam logic [7:0] STATUS_CTRL     = 8'hB0;
  localparam logic [7:0] META_PREFIX     = 8'hFF;
  localparam logic [7:0] META_EOT        = 8'h2F;
  localparam logic [6:0] NOTE_OFF_VEL    = 7'd64;
  localparam logic [6:0] DATA_MAX        = 7'h7F;

  // One classified event, ready for byte emission
  typedef struct packed {
    logic                  eot;
    logic [GRP_W-1:0]      top;     // index of the most significant delta group
    logic [NGRP-1:0][6:0]  grp;     // delta groups, least significant first
    logic [7:0]            status;
    logic [6:0]            data_a;
    logic [6:0]            data_b;
  } job_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // End-of-track sequence: zero delta, then FF 2F 00
  function automatic logic [7:0] eot_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd1:    b = META_PREFIX;
      2'd2:    b = META_EOT;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/core/mtes_if.sv
// Channel interfaces for input events and output track bytes.
interface mtes_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic signed [mtes_pkg::TICK_W-1:0] tick;
  logic signed [7:0]               channel;
  logic signed [8:0]               data_a;
  logic signed [8:0]               data_b;

  modport source (output valid, req_type, tick, channel, data_a, data_b, input ready);
  modport sink   (input valid, req_type, tick, channel, data_a, data_b, output ready);
endinterface

interface mtes_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_event;

  modport source (output valid, out_byte, last_of_event, input ready);
  modport sink   (input valid, out_byte, last_of_event, output ready);
endinterface

// File: rtl/core/midi_track_event_serializer_unit.sv
// Top level of the MIDI track event serializer.
// Each accepted event becomes its Standard MIDI File track bytes, one byte per
// cycle on the output channel while out_ch.ready allows, with last_of_event set
// on the final byte. A note or control event gives 4 to 8 bytes (1 to 5 delta
// bytes plus status and two data bytes); end of track gives four bytes (00 FF
// 2F 00). Input events are classified combinationally and queued two deep, so
// the input side takes events back to back while the queue has room and stalls
// independently of the output.
module midi_track_event_serializer_unit (
  input  logic        clk,
  input  logic        rst_n,
  mtes_in_if.sink     in_ch,
  mtes_out_if.source  out_ch
);
  import mtes_pkg::*;

  job_t            push_job;
  job_t            head_job;
  logic            q_push;
  logic            q_pop;
  q_stat_t         q_stat;
  logic [LT_W-1:0] last_tick;

  mtes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (push_job),
    .last_tick (last_tick)
  );

  mtes_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (head_job),
    .stat   (q_stat)
  );

  mtes_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .job    (head_job),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  // end of track returns the previous tick to zero
  a_eot_clears_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type == REQ_EOT) |=> (last_tick == '0))
    else $error("last tick not cleared after end of track");

  // queue cannot be full and empty at once
  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // retiring a job leaves its final byte in the output register
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_ch.valid && out_ch.last_of_event))
    else $error("job retired without a flagged final byte");

  // no job is taken from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

// File: rtl/core/mtes_front.sv
// Front end: accepts events, clamps fields, computes the delta and builds jobs.
module mtes_front (
  input  logic                    clk,
  input  logic                    rst_n,
  mtes_in_if.sink                 in_ch,
  input  mtes_pkg::q_stat_t       q_stat,
  output logic                    q_push,
  output mtes_pkg::job_t          q_job,
  output logic [mtes_pkg::LT_W-1:0] last_tick
);
  import mtes_pkg::*;

  logic [LT_W-1:0]      last_tick_r;
  logic [TICK_BITS-1:0] raw;
  logic [LT_W-1:0]      t;
  logic [LT_W-1:0]      delta;
  logic [DLY_W-1:0]     delta_pad;
  logic [7:0]           chm1;
  logic [3:0]           ch_nib;
  logic [6:0]           da;
  logic [6:0]           db;
  req_t                 rt;

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;
  assign last_tick   = last_tick_r;
  assign rt          = req_t'(in_ch.req_type);

  // Tick clamp and delta against the previous event
  always_comb begin
    raw       = in_ch.tick[TICK_BITS-1:0];
    t         = raw[TICK_BITS-1] ? '0 : raw[TICK_BITS-2:0];
    delta     = (t > last_tick_r) ? (t - last_tick_r) : '0;
    delta_pad = DLY_W'(delta);
  end

  // Field clamps
  always_comb begin
    chm1 = in_ch.channel - 8'sd1;
    if (in_ch.channel < 8'sd1) begin
      ch_nib = 4'd0;
    end else if (in_ch.channel > 8'sd16) begin
      ch_nib = 4'd15;
    end else begin
      ch_nib = chm1[3:0];
    end

    if (in_ch.data_a < 9'sd0) begin
      da = 7'd0;
    end else if (in_ch.data_a > 9'sd127) begin
      da = DATA_MAX;
    end else begin
      da = in_ch.data_a[6:0];
    end

    if (in_ch.data_b > 9'sd127) begin
      db = DATA_MAX;
    end else if (in_ch.data_b < 9'sd1) begin
      // note on never sends velocity 0
      db = (rt == REQ_NOTE_ON) ? 7'd1 : 7'd0;
    end else begin
      db = in_ch.data_b[6:0];
    end
  end

  // Job assembly
  always_comb begin
    q_job        = '0;
    q_job.eot    = (rt == REQ_EOT);
    q_job.data_a = da;
    for (int g = 0; g < NGRP; g++) begin
      q_job.grp[g] = delta_pad[g*7 +: 7];
    end
    q_job.top = '0;
    for (int g = 1; g < NGRP; g++) begin
      if (delta_pad[g*7 +: 7] != 7'd0) begin
        q_job.top = GRP_W'(g);
      end
    end
    unique case (rt)
      REQ_NOTE_ON: begin
        q_job.status = STATUS_NOTE_ON | {4'd0, ch_nib};
        q_job.data_b = db;
      end
      REQ_NOTE_OFF: begin
        q_job.status = STATUS_NOTE_OFF | {4'd0, ch_nib};
        q_job.data_b = NOTE_OFF_VEL;
      end
      REQ_CTRL: begin
        q_job.status = STATUS_CTRL | {4'd0, ch_nib};
        q_job.data_b = db;
      end
      default: begin
        q_job.status = 8'h00;
        q_job.data_b = 7'd0;
      end
    endcase
  end

  // Previous event tick; end of track returns it to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r <= '0;
    end else if (q_push) begin
      last_tick_r <= (rt == REQ_EOT) ? '0 : t;
    end
  end

endmodule

// File: rtl/core/mtes_queue.sv
// Short job queue between the front end and the byte emitter.
module mtes_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mtes_pkg::job_t     wr_job,
  input  logic               pop,
  output mtes_pkg::job_t     rd_job,
  output mtes_pkg::q_stat_t  stat
);
  import mtes_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rd_job     = slot_r[rd_ptr_r];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: rtl/core/mtes_back.sv
// Back end: walks one job byte by byte into the output register.
module mtes_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mtes_pkg::job_t     job,
  input  mtes_pkg::q_stat_t  q_stat,
  output logic               q_pop,
  mtes_out_if.source         out_ch
);
  import mtes_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic [POS_W-1:0] top_ext;
  logic [POS_W-1:0] k;
  logic [GRP_W-1:0] gi;
  logic [7:0]       byte_nxt;
  logic             last_nxt;
  logic             advance;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.last_of_event = out_last_r;

  assign advance = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign q_pop   = advance && last_nxt;

  // Byte select for the current position
  always_comb begin
    top_ext  = POS_W'(job.top);
    k        = pos_r - top_ext - POS_W'(1);
    gi       = GRP_W'(top_ext - pos_r);
    byte_nxt = 8'h00;
    if (job.eot) begin
      byte_nxt = eot_byte(pos_r[1:0]);
      last_nxt = (pos_r == POS_W'(3));
    end else begin
      last_nxt = (pos_r == top_ext + POS_W'(3));
      if (pos_r <= top_ext) begin
        // continuation bit on every delta byte but the lowest group
        byte_nxt = {gi != '0, job.grp[gi]};
      end else begin
        case (k)
          POS_W'(0): byte_nxt = job.status;
          POS_W'(1): byte_nxt = {1'b0, job.data_a};
          default:   byte_nxt = {1'b0, job.data_b};
        endcase
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

  // Control: valid flag and byte position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        pos_r       <= last_nxt ? '0 : pos_r + 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the MIDI track event serializer: random and directed events.
`timescale 1ns / 100ps

module testbench;
  import mtes_pkg::*;

  // One event waiting to be sent; hold makes the driver wait for the output to drain first
  typedef struct {
    req_t              kind;
    logic signed [31:0] tick;
    logic signed [7:0]  chan;
    logic signed [8:0]  da;
    logic signed [8:0]  db;
    bit                 hold;
  } evt_t;

  // One expected track byte
  typedef struct {
    logic [7:0] val;
    logic       last;
  } track_byte_t;

  logic clk;
  logic rst_n;

  mtes_in_if  in_ch ();
  mtes_out_if out_ch ();

  midi_track_event_serializer_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  evt_t            events_to_send[$];
  track_byte_t     track_bytes_due[$];
  logic [LT_W-1:0] prev_tick;
  bit              in_taken;
  bit              in_calm;
  bit              out_calm;
  int              in_gap;
  int              out_stall;
  int              sent_cnt;
  int              n_events;
  int              err_cnt;

  // Clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    err_cnt++;
  endtask

  function automatic void push_due(input logic [7:0] v, input logic l);
    track_byte_t b;
    b.val  = v;
    b.last = l;
    track_bytes_due.insert(track_bytes_due.size(), b);
  endfunction

  // Appends one event to the pending list
  function automatic void queue_evt(input evt_t e);
    events_to_send.insert(events_to_send.size(), e);
  endfunction

  // Predicts the track bytes of one event and advances the running tick
  function automatic void encode_track_event(input evt_t e);
    logic [LT_W-1:0]   t;
    logic [31:0]       delta;
    logic [7:0]        grp[5];
    logic [7:0]        status;
    logic signed [7:0] ch;
    logic [6:0]        num;
    logic [6:0]        vel;
    int                n;
    if (e.kind == REQ_EOT) begin
      push_due(8'h00, 1'b0);
      push_due(META_PREFIX, 1'b0);
      push_due(META_EOT, 1'b0);
      push_due(8'h00, 1'b1);
      prev_tick = '0;
      return;
    end
    // negative tick counts as zero, a step backwards as a zero delta
    t = e.tick[TICK_BITS-1] ? '0 : e.tick[TICK_BITS-2:0];
    delta = (t > prev_tick) ? 32'(t - prev_tick) : 32'd0;
    prev_tick = t;
    // variable-length quantity, continuation bit on all but the final group
    grp[0] = {1'b0, delta[6:0]};
    n = 1;
    delta = delta >> 7;
    while (delta != 0 && n < 5) begin
      grp[n] = {1'b1, delta[6:0]};
      n++;
      delta = delta >> 7;
    end
    for (int i = n - 1; i >= 0; i--) push_due(grp[i], 1'b0);
    // clamped channel and data bytes
    if (e.chan < 1) ch = 8'sd1;
    else if (e.chan > 16) ch = 8'sd16;
    else ch = e.chan;
    if (e.da < 0) num = 7'd0;
    else if (e.da > 127) num = DATA_MAX;
    else num = e.da[6:0];
    case (e.kind)
      REQ_NOTE_ON: begin
        status = STATUS_NOTE_ON;
        if (e.db < 1) vel = 7'd1;
        else if (e.db > 127) vel = DATA_MAX;
        else vel = e.db[6:0];
      end
      REQ_NOTE_OFF: begin
        status = STATUS_NOTE_OFF;
        vel = NOTE_OFF_VEL;
      end
      default: begin
        status = STATUS_CTRL;
        if (e.db < 0) vel = 7'd0;
        else if (e.db > 127) vel = DATA_MAX;
        else vel = e.db[6:0];
      end
    endcase
    push_due(status | {4'd0, 4'(ch - 8'sd1)}, 1'b0);
    push_due({1'b0, num}, 1'b0);
    push_due({1'b0, vel}, 1'b1);
  endfunction

  function automatic void add_evt(input req_t k, input logic [31:0] tk, input logic [7:0] ch,
                                  input logic [8:0] a, input logic [8:0] b);
    evt_t e;
    e.kind = k;
    e.tick = tk;
    e.chan = ch;
    e.da   = a;
    e.db   = b;
    e.hold = 1'b0;
    queue_evt(e);
  endfunction

  // Idle length: mostly short, a few long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // Sampling at the rising edge: predict on input accept, then check the output byte
  always @(posedge clk) begin
    evt_t        e;
    track_byte_t head;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) begin
      e.kind = req_t'(in_ch.req_type);
      e.tick = in_ch.tick;
      e.chan = in_ch.channel;
      e.da   = in_ch.data_a;
      e.db   = in_ch.data_b;
      e.hold = 1'b0;
      encode_track_event(e);
      sent_cnt++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (track_bytes_due.size() == 0) begin
        report_mismatch("unexpected byte", 0, out_ch.out_byte);
      end else begin
        head = track_bytes_due.pop_front();
        if (out_ch.out_byte !== head.val)
          report_mismatch("out_byte", head.val, out_ch.out_byte);
        if (out_ch.last_of_event !== head.last)
          report_mismatch("last_of_event", head.last, out_ch.last_of_event);
      end
    end
  end

  // Input driver, falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_taken) begin
        events_to_send.delete(0);
        if (in_calm || $urandom_range(0, 99) < 55) in_gap = 0;
        else in_gap = pick_idle();
        if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
      end
      if (!in_ch.valid || in_taken) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap--;
        end else if (events_to_send.size() != 0 &&
                     !(events_to_send[0].hold && track_bytes_due.size() != 0)) begin
          in_ch.req_type <= events_to_send[0].kind;
          in_ch.tick     <= events_to_send[0].tick;
          in_ch.channel  <= events_to_send[0].chan;
          in_ch.data_a   <= events_to_send[0].da;
          in_ch.data_b   <= events_to_send[0].db;
          in_ch.valid    <= 1'b1;
          events_to_send[0].hold = 1'b0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output backpressure, falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall--;
    end else begin
      out_ch.ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 99) < 25) out_stall = pick_idle();
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
    end
  end

  // Stimulus and end of run
  initial begin
    evt_t    e;
    longint  gen_tick;
    longint  nxt;
    longint  d;
    int      r;
    int      bits;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = '0;
    in_ch.tick     = '0;
    in_ch.channel  = '0;
    in_ch.data_a   = '0;
    in_ch.data_b   = '0;
    out_ch.ready   = 1'b0;
    prev_tick      = '0;

    // directed: delta widths at their limits, clamps, backwards and negative ticks, end of track
    add_evt(REQ_NOTE_ON, 0, 1, 0, 1);
    add_evt(REQ_NOTE_ON, 127, 16, 127, 127);
    add_evt(REQ_NOTE_OFF, 255, -128, -128, 255);
    add_evt(REQ_CTRL, 16638, 127, 255, -128);
    add_evt(REQ_CTRL, 33022, 0, 64, 255);
    add_evt(REQ_NOTE_ON, 2130174, 17, 60, 0);
    add_evt(REQ_NOTE_ON, 270565630, 5, 61, -1);
    add_evt(REQ_NOTE_ON, 270565630, 9, 62, 128);
    add_evt(REQ_NOTE_OFF, 1000, 3, 62, 0);
    add_evt(REQ_CTRL, -1, 2, 7, 100);
    add_evt(REQ_NOTE_ON, 32'h7fffffff, 10, 70, 90);
    add_evt(REQ_CTRL, 32'h80000000, 11, 1, 1);
    add_evt(REQ_EOT, 32'h12345678, -5, 200, -100);
    add_evt(REQ_NOTE_OFF, 100, 4, 40, 12);
    add_evt(REQ_EOT, 32'hfedcba98, 127, -128, 255);
    add_evt(REQ_EOT, 7, 1, 0, 0);
    add_evt(REQ_CTRL, 2097151, 16, 127, 127);
    add_evt(REQ_CTRL, 270532606, 8, 0, 0);
    add_evt(REQ_NOTE_ON, 270532606, 14, 33, 64);

    // random: mostly rising ticks with deltas of every length, some noise
    gen_tick = 270532606;
    for (int i = 0; i < 370; i++) begin
      e.kind = req_t'($urandom_range(0, 2));
      e.chan = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(1, 16)) : 8'($urandom);
      e.da   = ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 127))
                                            : 9'($urandom_range(0, 383) - 128);
      r = $urandom_range(0, 99);
      if (r < 5) e.db = 9'd0;
      else if (r < 85) e.db = 9'($urandom_range(0, 127));
      else e.db = 9'($urandom_range(0, 383) - 128);
      e.hold = (i == 0 || i == 200);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        e.kind   = REQ_EOT;
        e.tick   = $urandom;
        gen_tick = 0;
      end else if (r < 11) begin
        e.tick   = {1'b1, 31'($urandom)};
        gen_tick = 0;
      end else if (r < 16) begin
        e.tick   = {1'b0, 31'($urandom)};
        gen_tick = e.tick;
      end else begin
        case ($urandom_range(0, 9))
          0:          bits = 0;
          1, 2, 3, 4: bits = 7;
          5, 6:       bits = 14;
          7:          bits = 21;
          8:          bits = 28;
          default:    bits = 31;
        endcase
        d   = longint'($urandom) & ((64'd1 << bits) - 1);
        nxt = gen_tick + d;
        if (nxt > 64'h7fffffff) nxt = d;
        gen_tick = nxt;
        e.tick   = 32'(nxt);
      end
      queue_evt(e);
    end
    n_events = events_to_send.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain, then keep watching for stray bytes before the final check
    while (!(sent_cnt == n_events && track_bytes_due.size() == 0)) @(negedge clk);
    repeat (24) @(posedge clk);
    if (track_bytes_due.size() != 0)
      report_mismatch("bytes still due", track_bytes_due.size(), 0);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1500000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/core/mtes_pkg.sv
rtl/core/mtes_if.sv
rtl/core/mtes_front.sv
rtl/core/mtes_queue.sv
rtl/core/mtes_back.sv
rtl/core/midi_track_event_serializer_unit.sv
dv/testbench.sv
